// ===== rtl/ast_pkg.sv =====
// Shared types, constants and widths for the antialiased square tone synthesizer.
// Used by ast_regs, ast_div and antialiased_square_tone_synth; depends on nothing.
`default_nettype none

package ast_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int COUNT_BITS    = 10;
  localparam int SAMPLE_BITS   = 16;

  localparam int FSTEP_W   = 26;
  localparam int NUM_W     = 40;
  localparam int MIN_DIV_W = 16;
  localparam int AMP_W     = 15;
  localparam int DIVIN_W   = 16;

  localparam int DIV_ZERO_VALUE = 65536;

  localparam int PROD_W    = AMP_W + PHASE_BITS;
  localparam int DVD_W     = (NUM_W > PROD_W) ? NUM_W : PROD_W;
  localparam int DVS_W     = (PHASE_BITS > DIVIN_W + 1) ? PHASE_BITS : DIVIN_W + 1;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 2;

  localparam logic [1:0] CMD_GATE    = 2'd0;
  localparam logic [1:0] CMD_DIVISOR = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_STEP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TONE_NUM   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DIV    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 2'd3;

  localparam logic [FSTEP_W-1:0]   FRAME_STEP_RST = 26'd44884015;
  localparam logic [NUM_W-1:0]     TONE_NUM_RST   = 40'd106764117937;
  localparam logic [MIN_DIV_W-1:0] MIN_DIV_RST    = 16'd60;
  localparam logic [AMP_W-1:0]     AMPLITUDE_RST  = 15'd16383;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]         command;
    logic               gate_on;
    logic [DIVIN_W-1:0] divisor;
  } ast_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          frame_last;
  } ast_out_t;

  typedef struct packed {
    logic [FSTEP_W-1:0]   frame_step;
    logic [NUM_W-1:0]     tone_numerator;
    logic [MIN_DIV_W-1:0] min_audible_divisor;
    logic [AMP_W-1:0]     amplitude;
  } ast_cfg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } ast_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ast_div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/antialiased_square_tone_synth.sv =====
// Top level: one request at a time. Gate, ignored or silent divisor writes and samples without
// a tone go straight to the output register; a divisor write that divides and a tone sample
// first wait for the serial divider (47 quotient bits, one a cycle).
// The next request is accepted in the cycle after the result is loaded;
// the result may wait in the output register meanwhile.
// Reset is synchronous and active high: state clears, registers return to defaults.
`default_nettype none

module antialiased_square_tone_synth
  import ast_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire ast_in_t               req,
  output logic                       smp_valid,
  input  wire logic                  smp_stall,
  output ast_out_t                   smp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TRI  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIVS = 3'd4;
  localparam logic [2:0] S_DIVW = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam int ACC_W = FSTEP_W + 1;
  localparam int N_W   = ACC_W - FRACTION_BITS;
  localparam int CMP_W = (N_W > COUNT_BITS + 1) ? N_W : COUNT_BITS + 1;

  function automatic logic [PHASE_BITS-1:0] tri_wave(input logic [PHASE_BITS-1:0] p);
    tri_wave = p[PHASE_BITS-1] ? (PHASE_BITS'(0) - p) : p;
  endfunction

  ast_cfg_t     cfg;
  ast_div_req_t div_req;
  ast_div_sts_t div_sts;
  logic [DVD_W-1:0] quo;

  logic [2:0]             state;
  ast_in_t                cmd_q;
  logic                   gate_enabled;
  logic [PHASE_BITS-1:0]  wave_phase;
  logic [FRACTION_BITS-1:0] frame_fraction;
  logic [COUNT_BITS-1:0]  samples_left;
  logic [PHASE_BITS-1:0]  phase_step;
  logic                   frame_silent;
  logic [PHASE_BITS-1:0]  phase_next;
  logic [PHASE_BITS-1:0]  diff;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] res_sample;
  logic                   res_valid;
  logic                   res_last;

  logic [ACC_W-1:0]       acc;
  logic [CMP_W-1:0]       n_ext;
  logic [COUNT_BITS-1:0]  count_sat;
  logic                   silent_hit;
  logic [DVS_W-1:0]       div_operand;
  logic [PHASE_BITS-1:0]  t0;
  logic [PHASE_BITS-1:0]  t1;
  logic [PROD_W-1:0]      prod;
  logic [PHASE_BITS-1:0]  step_sat;
  logic [SAMPLE_BITS-1:0] q_low;
  logic                   q_hi;
  logic                   ovf_pos;
  logic                   ovf_neg;
  logic [SAMPLE_BITS-1:0] sample_sat;
  logic                   emit_ok;

  ast_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ast_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .sts      (div_sts),
    .quotient (quo)
  );

  assign req_stall = state != S_IDLE;
  assign emit_ok   = !smp_valid || !smp_stall;

  always_comb begin
    acc         = ACC_W'(cfg.frame_step) + ACC_W'(frame_fraction);
    n_ext       = CMP_W'(acc[ACC_W-1:FRACTION_BITS]);
    count_sat   = (|n_ext[CMP_W-1:COUNT_BITS]) ? {COUNT_BITS{1'b1}} : n_ext[COUNT_BITS-1:0];
    silent_hit  = (cmd_q.divisor != '0) &&
                  (MIN_DIV_W'(cmd_q.divisor) < cfg.min_audible_divisor);
    div_operand = (cmd_q.divisor == '0) ? DVS_W'(DIV_ZERO_VALUE) : DVS_W'(cmd_q.divisor);
    t0          = tri_wave(wave_phase);
    t1          = tri_wave(phase_next);
    prod        = PROD_W'(cfg.amplitude) * PROD_W'(diff);
    step_sat    = (|quo[DVD_W-1:PHASE_BITS]) ? {PHASE_BITS{1'b1}} : quo[PHASE_BITS-1:0];
    q_low       = quo[SAMPLE_BITS-1:0];
    q_hi        = |quo[DVD_W-1:SAMPLE_BITS];
    ovf_pos     = q_hi || quo[SAMPLE_BITS-1];
    ovf_neg     = q_hi || (quo[SAMPLE_BITS-1] && (|quo[SAMPLE_BITS-2:0]));
    if (neg) begin
      sample_sat = ovf_neg ? SAMPLE_NEG_MAX : (SAMPLE_BITS'(0) - q_low);
    end else begin
      sample_sat = ovf_pos ? SAMPLE_POS_MAX : q_low;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(cfg.tone_numerator);
    div_req.divisor  = div_operand;
    if (state == S_EXEC) begin
      div_req.start = (cmd_q.command == CMD_DIVISOR) && gate_enabled && !silent_hit;
    end else if (state == S_MUL) begin
      div_req.start    = 1'b1;
      div_req.dividend = DVD_W'(prod);
      div_req.divisor  = DVS_W'(phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      gate_enabled   <= 1'b0;
      wave_phase     <= '0;
      frame_fraction <= '0;
      samples_left   <= '0;
      phase_step     <= '0;
      frame_silent   <= 1'b0;
      smp_valid      <= 1'b0;
    end else begin
      if (state == S_EMIT && emit_ok) begin
        smp_valid <= 1'b1;
      end else if (smp_valid && !smp_stall) begin
        smp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_q.command)
            CMD_GATE: begin
              gate_enabled <= cmd_q.gate_on;
              state        <= S_EMIT;
            end
            CMD_DIVISOR: begin
              if (gate_enabled) begin
                frame_fraction <= acc[FRACTION_BITS-1:0];
                samples_left   <= count_sat;
                if (silent_hit) begin
                  frame_silent <= 1'b1;
                  phase_step   <= '0;
                  state        <= S_EMIT;
                end else begin
                  frame_silent <= 1'b0;
                  state        <= S_DIVW;
                end
              end else begin
                state <= S_EMIT;
              end
            end
            CMD_SAMPLE: begin
              if (samples_left != '0) begin
                samples_left <= samples_left - 1'b1;
              end
              if (samples_left != '0 && !frame_silent && phase_step != '0) begin
                state <= S_TRI;
              end else begin
                state <= S_EMIT;
              end
            end
            default: begin
              state <= S_EMIT;
            end
          endcase
        end
        S_TRI: begin
          wave_phase <= phase_next;
          state      <= S_MUL;
        end
        S_MUL: begin
          state <= S_DIVS;
        end
        S_DIVS: begin
          if (div_sts.done) begin
            state <= S_EMIT;
          end
        end
        S_DIVW: begin
          if (div_sts.done) begin
            phase_step <= step_sat;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cmd_q <= req;
    end
    if (state == S_EXEC) begin
      res_sample <= '0;
      res_valid  <= (cmd_q.command == CMD_SAMPLE) && (samples_left != '0);
      res_last   <= (cmd_q.command == CMD_SAMPLE) && (samples_left == COUNT_BITS'(1));
      phase_next <= wave_phase + phase_step;
    end
    if (state == S_TRI) begin
      neg  <= t1 < t0;
      diff <= (t1 < t0) ? (t0 - t1) : (t1 - t0);
    end
    if (state == S_DIVS && div_sts.done) begin
      res_sample <= sample_sat;
    end
    if (state == S_EMIT && emit_ok) begin
      smp.sample       <= res_sample;
      smp.sample_valid <= res_valid;
      smp.frame_last   <= res_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) frame_silent |-> phase_step == '0)
    else $error("silent frame carries a nonzero phase step");

  assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_DIVW || state == S_DIVS))
    else $error("divider finished while no state waits for it");

  assert property (@(posedge clk) disable iff (rst) div_req.start |-> !div_sts.busy)
    else $error("divider started while still busy");

  assert property (@(posedge clk) disable iff (rst)
    (smp_valid && !smp.sample_valid) |-> (smp.sample == '0 && !smp.frame_last))
    else $error("result without a frame sample has nonzero fields");

endmodule

`default_nettype wire

// ===== rtl/ast_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on ast_pkg for register codes, reset values and the config struct.
`default_nettype none

module ast_regs
  import ast_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output ast_cfg_t                   cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_step          <= FRAME_STEP_RST;
      cfg.tone_numerator      <= TONE_NUM_RST;
      cfg.min_audible_divisor <= MIN_DIV_RST;
      cfg.amplitude           <= AMPLITUDE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_STEP: cfg.frame_step          <= pwdata[FSTEP_W-1:0];
        REG_TONE_NUM:   cfg.tone_numerator      <= pwdata[NUM_W-1:0];
        REG_MIN_DIV:    cfg.min_audible_divisor <= pwdata[MIN_DIV_W-1:0];
        REG_AMPLITUDE:  cfg.amplitude           <= pwdata[AMP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_STEP: prdata = APB_DATA_W'(cfg.frame_step);
      REG_TONE_NUM:   prdata = APB_DATA_W'(cfg.tone_numerator);
      REG_MIN_DIV:    prdata = APB_DATA_W'(cfg.min_audible_divisor);
      REG_AMPLITUDE:  prdata = APB_DATA_W'(cfg.amplitude);
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ast_div.sv =====
// Shared serial restoring divider, one quotient bit per cycle.
// Depends on ast_pkg for operand widths and the request and status structs.
`default_nettype none

module ast_div
  import ast_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ast_div_req_t req,
  output ast_div_sts_t      sts,
  output logic [DVD_W-1:0]  quotient
);

  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W:0]       trial;
  logic                 qbit;
  logic [DVS_W:0]       diff;

  always_comb begin
    trial = {rem, quotient[DVD_W-1]};
    qbit  = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= !req.start && sts.busy && (cnt == '0);
      if (req.start) begin
        sts.busy <= 1'b1;
      end else if (sts.busy && cnt == '0) begin
        sts.busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      dvs      <= req.divisor;
      rem      <= '0;
      cnt      <= DIV_CNT_W'(DVD_W - 1);
    end else if (sts.busy) begin
      quotient <= {quotient[DVD_W-2:0], qbit};
      rem      <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tone_sample_checker.sv =====
`timescale 1ns / 100ps
// Checker for antialiased_square_tone_synth: follows the request, sample and register
// channels, predicts every sample with its own copy of the tone state and compares.
// Depends on ast_pkg only.
module tone_sample_checker
  import ast_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  ast_in_t               req,
  input  logic                  smp_valid,
  input  logic                  smp_stall,
  input  ast_out_t              smp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending
);

  localparam logic [63:0] COUNT_LIMIT = (64'd1 << COUNT_BITS) - 64'd1;
  localparam logic [63:0] PHASE_LIMIT = (64'd1 << PHASE_BITS) - 64'd1;
  localparam logic [63:0] PHASE_WRAP  = 64'd1 << PHASE_BITS;
  localparam logic [63:0] POS_LIMIT   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

  ast_cfg_t                 cfg;
  logic                     gate_q;
  logic [PHASE_BITS-1:0]    phase_q;
  logic [PHASE_BITS-1:0]    step_q;
  logic [FRACTION_BITS-1:0] frac_q;
  logic [COUNT_BITS-1:0]    left_q;
  logic                     silent_q;
  ast_out_t                 expected_samples[$];
  ast_out_t                 want;
  int                       err_cnt = 0;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    err_cnt++;
  endtask

  // Integral of the square wave: rises over the first half cycle, falls over the second.
  function automatic logic [63:0] tri_level(input logic [PHASE_BITS-1:0] ph);
    if (!ph[PHASE_BITS-1]) return {{(64-PHASE_BITS){1'b0}}, ph};
    return PHASE_WRAP - {{(64-PHASE_BITS){1'b0}}, ph};
  endfunction

  task automatic synth_tone_step(input ast_in_t r, output ast_out_t o);
    logic [63:0]           acc;
    logic [63:0]           dvs;
    logic [63:0]           quo;
    logic [63:0]           lvl0;
    logic [63:0]           lvl1;
    logic [63:0]           mag;
    logic [63:0]           neg;
    logic [PHASE_BITS-1:0] nxt;
    o = '0;
    case (r.command)
      CMD_GATE: gate_q = r.gate_on;
      CMD_DIVISOR: begin
        if (gate_q) begin
          acc = frac_q + cfg.frame_step;
          frac_q = acc[FRACTION_BITS-1:0];
          acc = acc >> FRACTION_BITS;
          left_q = (acc > COUNT_LIMIT) ? COUNT_LIMIT[COUNT_BITS-1:0] : acc[COUNT_BITS-1:0];
          if (r.divisor != '0 && r.divisor < cfg.min_audible_divisor) begin
            silent_q = 1'b1;
            step_q = '0;
          end else begin
            dvs = (r.divisor == '0) ? DIV_ZERO_VALUE : r.divisor;
            quo = cfg.tone_numerator / dvs;
            silent_q = 1'b0;
            step_q = (quo > PHASE_LIMIT) ? PHASE_LIMIT[PHASE_BITS-1:0] : quo[PHASE_BITS-1:0];
          end
        end
      end
      CMD_SAMPLE: begin
        if (left_q != '0) begin
          o.sample_valid = 1'b1;
          o.frame_last = (left_q == 1);
          left_q = left_q - 1'b1;
          if (!silent_q && step_q != '0) begin
            nxt = phase_q + step_q;
            lvl0 = tri_level(phase_q);
            lvl1 = tri_level(nxt);
            if (lvl1 >= lvl0) begin
              mag = (cfg.amplitude * (lvl1 - lvl0)) / step_q;
              o.sample = (mag > POS_LIMIT) ? SAMPLE_POS_MAX : mag[SAMPLE_BITS-1:0];
            end else begin
              mag = (cfg.amplitude * (lvl0 - lvl1)) / step_q;
              neg = 64'd0 - mag;
              o.sample = (mag > POS_LIMIT + 64'd1) ? SAMPLE_NEG_MAX : neg[SAMPLE_BITS-1:0];
            end
            phase_q = nxt;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.frame_step = FRAME_STEP_RST;
      cfg.tone_numerator = TONE_NUM_RST;
      cfg.min_audible_divisor = MIN_DIV_RST;
      cfg.amplitude = AMPLITUDE_RST;
      gate_q = 1'b0;
      phase_q = '0;
      step_q = '0;
      frac_q = '0;
      left_q = '0;
      silent_q = 1'b0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3 +: REG_IDX_W])
          REG_FRAME_STEP: cfg.frame_step = pwdata[FSTEP_W-1:0];
          REG_TONE_NUM:   cfg.tone_numerator = pwdata[NUM_W-1:0];
          REG_MIN_DIV:    cfg.min_audible_divisor = pwdata[MIN_DIV_W-1:0];
          REG_AMPLITUDE:  cfg.amplitude = pwdata[AMP_W-1:0];
          default: ;
        endcase
      end
      if (smp_valid && !smp_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected sample", smp.sample, 0);
        end else begin
          want = expected_samples.pop_front();
          if (smp.sample !== want.sample)
            report_mismatch("sample", smp.sample, want.sample);
          if (smp.sample_valid !== want.sample_valid)
            report_mismatch("sample_valid", smp.sample_valid, want.sample_valid);
          if (smp.frame_last !== want.frame_last)
            report_mismatch("frame_last", smp.frame_last, want.frame_last);
        end
      end
      if (req_valid && !req_stall) begin
        synth_tone_step(req, want);
        expected_samples.push_back(want);
      end
    end
    mismatches <= err_cnt;
    pending <= expected_samples.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for antialiased_square_tone_synth: makes requests, register writes and
// sample back-pressure, and gives the verdict from the counts of tone_sample_checker.
// Depends on ast_pkg, tone_sample_checker and the block's RTL.
module tb;
  import ast_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  ast_in_t                req = '0;
  logic                   smp_valid;
  logic                   smp_stall = 1'b0;
  ast_out_t               smp;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  int                     mismatches;
  int                     pending;
  int                     snd_idle_pct = 0;
  int                     rcv_idle_pct = 0;
  logic                   hold_tgl = 1'b0;
  logic                   hold_seen = 1'b0;
  int                     hold_left = 0;
  int                     cycles = 0;
  logic                   gate_shadow = 1'b0;
  int                     frame_len = 1;
  logic [MIN_DIV_W-1:0]   min_div = MIN_DIV_RST;

  antialiased_square_tone_synth u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp       (smp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tone_sample_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .smp_valid  (smp_valid),
    .smp_stall  (smp_stall),
    .smp        (smp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The sample side stalls at random, or for a long stretch when asked by a toggle.
  always @(posedge clk) begin
    if (hold_seen != hold_tgl) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      smp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      smp_stall <= 1'b1;
    end else begin
      smp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  function automatic ast_in_t mk_req(input logic [1:0] cmd, input logic gate,
                                     input logic [DIVIN_W-1:0] div);
    ast_in_t r;
    r.command = cmd;
    r.gate_on = gate;
    r.divisor = div;
    return r;
  endfunction

  function automatic logic [DIVIN_W-1:0] pick_divisor();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DIVIN_W'($urandom_range(1, min_div - 1));
      3: return min_div;
      4: return min_div - 1'b1;
      5: return DIVIN_W'($urandom_range(min_div, min_div + 200));
      default: return DIVIN_W'($urandom);
    endcase
  endfunction

  task automatic send_req(input ast_in_t item);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 3'b000});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [FSTEP_W-1:0] fstep, input logic [NUM_W-1:0] num,
                            input logic [MIN_DIV_W-1:0] mind, input logic [AMP_W-1:0] amp);
    reg_write(REG_FRAME_STEP, APB_DATA_W'(fstep));
    reg_write(REG_TONE_NUM, APB_DATA_W'(num));
    reg_write(REG_MIN_DIV, APB_DATA_W'(mind));
    reg_write(REG_AMPLITUDE, APB_DATA_W'(amp));
    frame_len = int'(fstep >> FRACTION_BITS) + 1;
    min_div = mind;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly whole frames: a divisor write followed by about a frame of sample requests.
  task automatic run_random(input int n);
    int      sent;
    int      k;
    ast_in_t it;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 80) begin
        if (!gate_shadow || $urandom_range(0, 9) == 0) begin
          send_req(mk_req(CMD_GATE, 1'b1, DIVIN_W'($urandom)));
          gate_shadow = 1'b1;
          sent++;
        end
        send_req(mk_req(CMD_DIVISOR, 1'($urandom), pick_divisor()));
        k = $urandom_range(0, frame_len + 2);
        for (int j = 0; j < k; j++)
          send_req(mk_req(CMD_SAMPLE, 1'($urandom), DIVIN_W'($urandom)));
        sent += k + 1;
      end else begin
        it.command = 2'($urandom_range(0, 3));
        it.gate_on = 1'($urandom);
        it.divisor = DIVIN_W'($urandom);
        if (it.command == CMD_GATE) gate_shadow = it.gate_on;
        send_req(it);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    snd_idle_pct = 36;
    rcv_idle_pct = 79;

    send_req(mk_req(CMD_UNUSED, 1'b1, 16'hFFFF));
    send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b1, 16'd1000));
    send_req(mk_req(CMD_SAMPLE, 1'b1, 16'hFFFF));
    send_req(mk_req(CMD_GATE, 1'b1, 16'h5A5A));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd1000));
    repeat (3) send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd0));
    repeat (2) send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd59));
    send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd60));
    repeat (2) send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_GATE, 1'b0, 16'hA5A5));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd500));
    send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    wait_idle();

    set_config('1, '1, 16'd25, '1);
    send_req(mk_req(CMD_GATE, 1'b1, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd25));
    repeat (2) send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd24));
    send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'd0));
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'hFFFF));
    send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    wait_idle();

    set_config('0, '0, 16'hFFFF, '0);
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'hFFFE));
    send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    wait_idle();

    set_config(26'h20000, '0, 16'hFFFF, '0);
    send_req(mk_req(CMD_DIVISOR, 1'b0, 16'hFFFF));
    repeat (3) send_req(mk_req(CMD_SAMPLE, 1'b0, 16'h0000));
    wait_idle();
    gate_shadow = 1'b1;

    set_config(26'h28000, TONE_NUM_RST, MIN_DIV_RST, AMPLITUDE_RST);
    run_random(60);
    hold_tgl <= ~hold_tgl;
    run_random(60);
    wait_idle();

    snd_idle_pct = 79;
    rcv_idle_pct = 36;
    set_config(FSTEP_W'($urandom_range(32'h10000, 32'h60000)),
               {8'($urandom), 32'($urandom)}, MIN_DIV_W'($urandom_range(25, 3000)),
               AMP_W'($urandom));
    run_random(120);
    wait_idle();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(26'h10000, '1, 16'd25, '1);
    run_random(100);
    wait_idle();

    set_config(FSTEP_W'($urandom_range(32'h8000, 32'h48000)),
               {8'($urandom), 32'($urandom)}, 16'hFFFF, AMP_W'($urandom));
    run_random(110);
    wait_idle();

    if (mismatches == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
